/* design/wfpe_pkg.sv */
// wfpe_pkg: shared types, constants and the brightness table of the ws2812 frame encoder
// no dependencies
`timescale 1ns / 1ps

package wfpe_pkg;

    // chain geometry
    localparam int LED_COUNT    = 64;
    localparam int RESET_SLOTS  = 50;
    localparam int BITS_PER_LED = 24;
    localparam int LED_AW       = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam int MAX_ANGLE    = 45;

    // register reset values
    localparam logic       BRIGHT_EN_RST  = 1'b1;
    localparam logic [5:0] BRIGHT_LVL_RST = 6'd45;
    localparam logic [7:0] DUTY_ONE_RST   = 8'd60;
    localparam logic [7:0] DUTY_ZERO_RST  = 8'd30;

    // item function codes
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_SLOT  = 1'b1;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_BRIGHT_EN  = 2'd0,
        CFG_BRIGHT_LVL = 2'd1,
        CFG_DUTY_ONE   = 2'd2,
        CFG_DUTY_ZERO  = 2'd3
    } cfg_index_t;

    // colour byte lanes within a bit slot count
    localparam logic [1:0] LANE_GREEN = 2'd0;
    localparam logic [1:0] LANE_RED   = 2'd1;
    localparam logic [1:0] LANE_BLUE  = 2'd2;

    typedef struct packed {
        logic       func;
        logic [5:0] led_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } in_item_t;

    typedef struct packed {
        logic [7:0] duty;
        logic       frame_end;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCALE,
        ST_EMIT
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic mul_en;
        logic load_out;
        logic clear_out;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_full;
    } dp_status_t;

    // round(tan(k deg) * 65536); levels above the top saturate to a scale of one
    function automatic logic [16:0] tan_q16(input logic [5:0] lvl);
        logic [16:0] t;
        case (lvl)
            6'd0:  t = 17'd0;
            6'd1:  t = 17'd1144;
            6'd2:  t = 17'd2289;
            6'd3:  t = 17'd3435;
            6'd4:  t = 17'd4583;
            6'd5:  t = 17'd5734;
            6'd6:  t = 17'd6888;
            6'd7:  t = 17'd8047;
            6'd8:  t = 17'd9210;
            6'd9:  t = 17'd10380;
            6'd10: t = 17'd11556;
            6'd11: t = 17'd12739;
            6'd12: t = 17'd13930;
            6'd13: t = 17'd15130;
            6'd14: t = 17'd16340;
            6'd15: t = 17'd17560;
            6'd16: t = 17'd18792;
            6'd17: t = 17'd20036;
            6'd18: t = 17'd21294;
            6'd19: t = 17'd22566;
            6'd20: t = 17'd23853;
            6'd21: t = 17'd25157;
            6'd22: t = 17'd26478;
            6'd23: t = 17'd27818;
            6'd24: t = 17'd29179;
            6'd25: t = 17'd30560;
            6'd26: t = 17'd31964;
            6'd27: t = 17'd33392;
            6'd28: t = 17'd34846;
            6'd29: t = 17'd36327;
            6'd30: t = 17'd37837;
            6'd31: t = 17'd39378;
            6'd32: t = 17'd40951;
            6'd33: t = 17'd42560;
            6'd34: t = 17'd44205;
            6'd35: t = 17'd45889;
            6'd36: t = 17'd47615;
            6'd37: t = 17'd49385;
            6'd38: t = 17'd51202;
            6'd39: t = 17'd53070;
            6'd40: t = 17'd54991;
            6'd41: t = 17'd56970;
            6'd42: t = 17'd59009;
            6'd43: t = 17'd61113;
            6'd44: t = 17'd63287;
            default: t = 17'd65536;
        endcase
        return t;
    endfunction

endpackage

/* design/wfpe_ctrl.sv */
// wfpe_ctrl: sequencing state machine of the frame encoder
// depends on wfpe_pkg
`timescale 1ns / 1ps

module wfpe_ctrl
    import wfpe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_func,
    output logic       in_ready,
    input  logic       out_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next    = state_reg;
        in_ready      = 1'b0;
        cmd           = '0;
        cmd.clear_out = status.out_full && out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_func == FUNC_SLOT)
                    begin
                        cmd.rd_en  = 1'b1;
                        state_next = ST_SCALE;
                    end
                    else
                    begin
                        cmd.wr_en = 1'b1;
                    end
                end
            end
            ST_SCALE:
            begin
                cmd.mul_en = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                // output register free or being emptied this cycle
                if (!status.out_full || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* design/wfpe_datapath.sv */
// wfpe_datapath: colour store, slot position counters, brightness scaling and output register
// depends on wfpe_pkg
`timescale 1ns / 1ps

module wfpe_datapath
    import wfpe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  dp_cmd_t    cmd,
    output dp_status_t status,
    input  in_item_t   in_data,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    output logic       out_valid,
    output out_item_t  out_data
);

    // configuration registers
    logic       bright_en_reg;
    logic [5:0] bright_lvl_reg;
    logic [7:0] duty_one_reg;
    logic [7:0] duty_zero_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bright_en_reg  <= BRIGHT_EN_RST;
            bright_lvl_reg <= BRIGHT_LVL_RST;
            duty_one_reg   <= DUTY_ONE_RST;
            duty_zero_reg  <= DUTY_ZERO_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_BRIGHT_EN:  bright_en_reg  <= cfg_data[0];
                CFG_BRIGHT_LVL: bright_lvl_reg <= cfg_data[5:0];
                CFG_DUTY_ONE:   duty_one_reg   <= cfg_data;
                CFG_DUTY_ZERO:  duty_zero_reg  <= cfg_data;
                default:        bright_en_reg  <= bright_en_reg;
            endcase
        end
    end

    // colour store, G in the top byte; valid bits stand for the cleared reset state
    logic [23:0]          store_mem [LED_COUNT];
    logic [LED_COUNT-1:0] store_vld_reg;
    logic [LED_AW-1:0]    wr_addr;
    logic                 wr_hit;
    logic [23:0]          rd_data_reg;
    logic                 rd_hit_reg;
    logic [LED_AW-1:0]    led_cnt_reg;

    assign wr_addr = LED_AW'(in_data.led_index);
    assign wr_hit  = cmd.wr_en && (32'(in_data.led_index) < LED_COUNT);

    always_ff @(posedge clk)
    begin
        if (wr_hit)
        begin
            store_mem[wr_addr] <= {in_data.green, in_data.red, in_data.blue};
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= store_mem[led_cnt_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            store_vld_reg <= '0;
            rd_hit_reg    <= 1'b0;
        end
        else
        begin
            if (wr_hit)
            begin
                store_vld_reg[wr_addr] <= 1'b1;
            end
            if (cmd.rd_en)
            begin
                rd_hit_reg <= store_vld_reg[led_cnt_reg];
            end
        end
    end

    // slot position: led and bit counters in the data part, then the reset slots
    logic       in_data_part_reg;
    logic [4:0] bit_cnt_reg;
    logic [7:0] rst_cnt_reg;
    logic       last_bit;
    logic       last_led;
    logic       last_rst;

    assign last_bit = (bit_cnt_reg == 5'(BITS_PER_LED - 1));
    assign last_led = (led_cnt_reg == LED_AW'(LED_COUNT - 1));
    assign last_rst = (rst_cnt_reg == 8'(RESET_SLOTS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_data_part_reg <= 1'b1;
            bit_cnt_reg      <= '0;
            led_cnt_reg      <= '0;
            rst_cnt_reg      <= '0;
        end
        else if (cmd.rd_en)
        begin
            if (in_data_part_reg)
            begin
                if (last_bit)
                begin
                    bit_cnt_reg <= '0;
                    if (last_led)
                    begin
                        led_cnt_reg      <= '0;
                        in_data_part_reg <= 1'b0;
                    end
                    else
                    begin
                        led_cnt_reg <= led_cnt_reg + 1'b1;
                    end
                end
                else
                begin
                    bit_cnt_reg <= bit_cnt_reg + 1'b1;
                end
            end
            else
            begin
                if (last_rst)
                begin
                    rst_cnt_reg      <= '0;
                    in_data_part_reg <= 1'b1;
                end
                else
                begin
                    rst_cnt_reg <= rst_cnt_reg + 1'b1;
                end
            end
        end
    end

    // slot details captured with the store read
    logic       slot_data_reg;
    logic       slot_end_reg;
    logic [4:0] slot_bit_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            slot_data_reg <= in_data_part_reg;
            slot_end_reg  <= !in_data_part_reg && last_rst;
            slot_bit_reg  <= bit_cnt_reg;
        end
    end

    // lane select and brightness multiply
    logic [23:0] colour;
    logic [7:0]  lane;
    logic [24:0] product;
    logic [5:0]  lvl_sat;
    logic [7:0]  scaled_reg;

    assign colour  = rd_hit_reg ? rd_data_reg : 24'd0;
    assign lvl_sat = (bright_lvl_reg > 6'(MAX_ANGLE)) ? 6'(MAX_ANGLE) : bright_lvl_reg;

    always_comb
    begin
        case (slot_bit_reg[4:3])
            LANE_GREEN: lane = colour[23:16];
            LANE_RED:   lane = colour[15:8];
            LANE_BLUE:  lane = colour[7:0];
            default:    lane = colour[7:0];
        endcase
    end

    assign product = 25'(lane) * 25'(tan_q16(lvl_sat));

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            scaled_reg <= bright_en_reg ? product[23:16] : lane;
        end
    end

    // output register
    logic      out_valid_reg;
    out_item_t out_data_reg;
    out_item_t out_next;

    always_comb
    begin
        out_next.frame_end = slot_end_reg;
        if (!slot_data_reg)
        begin
            out_next.duty = 8'd0;
        end
        else if (scaled_reg[~slot_bit_reg[2:0]])
        begin
            out_next.duty = duty_one_reg;
        end
        else
        begin
            out_next.duty = duty_zero_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_data_reg <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (cmd.clear_out)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_data        = out_data_reg;
    assign status.out_full = out_valid_reg;

    // checks
    a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
        bit_cnt_reg <= 5'(BITS_PER_LED - 1))
        else $error("bit counter beyond last bit of an led");

    a_rst_range: assert property (@(posedge clk) disable iff (!rst_n)
        rst_cnt_reg <= 8'(RESET_SLOTS - 1))
        else $error("reset slot counter beyond frame");

    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> out_valid_reg)
        else $error("loaded item not shown as valid");

    a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.frame_end) |-> (out_data_reg.duty == 8'd0))
        else $error("frame end item carries a non-zero duty");

endmodule

/* design/ws2812_frame_pwm_encoder.sv */
// ws2812_frame_pwm_encoder: top level, joins controller and datapath
// depends on wfpe_pkg, wfpe_ctrl, wfpe_datapath
//
//  channel | handshake            | payload
//  --------+----------------------+----------------------------------------
//  in      | in_valid / in_ready  | in_data: func, led_index, red, green, blue
//  out     | out_valid / out_ready| out_data: duty, frame_end
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data (always ready)
//
// a write item is taken in the idle state; a slot item takes three steps (store read,
// registered brightness multiply, output load), and no new item is accepted until its load
// the output register holds a finished item while the next item is accepted
// a stalled output holds the third step until the register frees
// reset clears the colour store valid bits, so all leds read as zero at once
`timescale 1ns / 1ps

module ws2812_frame_pwm_encoder
    import wfpe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  in_item_t   in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output out_item_t  out_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // configuration writes are taken in any cycle
    assign cfg_ready = 1'b1;

    wfpe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_func   (in_data.func),
        .in_ready  (in_ready),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    wfpe_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (in_data),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule

/* tb/sv/ws2812_tb_pkg.sv */
// ws2812_tb_pkg: tracking model and result checker for the ws2812 frame encoder bench
// depends on wfpe_pkg for the item structs, function codes and register indexes
`timescale 1ns / 1ps

package ws2812_tb_pkg;
    import wfpe_pkg::*;

    localparam int LED_SLOTS  = LED_COUNT * BITS_PER_LED;
    localparam int FRAME_LEN  = LED_SLOTS + RESET_SLOTS;
    localparam int TOP_ANGLE  = 45;
    localparam int SHOWN_ERRS = 10;

    // tan(k deg) in q1.16, k = 0..45
    localparam logic [16:0] TAN_Q16_LUT [46] = '{
        17'd0,     17'd1144,  17'd2289,  17'd3435,  17'd4583,  17'd5734,
        17'd6888,  17'd8047,  17'd9210,  17'd10380, 17'd11556, 17'd12739,
        17'd13930, 17'd15130, 17'd16340, 17'd17560, 17'd18792, 17'd20036,
        17'd21294, 17'd22566, 17'd23853, 17'd25157, 17'd26478, 17'd27818,
        17'd29179, 17'd30560, 17'd31964, 17'd33392, 17'd34846, 17'd36327,
        17'd37837, 17'd39378, 17'd40951, 17'd42560, 17'd44205, 17'd45889,
        17'd47615, 17'd49385, 17'd51202, 17'd53070, 17'd54991, 17'd56970,
        17'd59009, 17'd61113, 17'd63287, 17'd65536
    };

    // follows the led colours, frame position and registers, and checks each slot code
    class frame_slot_tracker;
        logic        scale_on;
        logic [5:0]  angle;
        logic [7:0]  code_one;
        logic [7:0]  code_zero;
        logic [23:0] grb_store [LED_COUNT];
        int          slot_pos;
        out_item_t   pending_codes [$];
        int          mismatches;
        int          stray_codes;
        int          codes_checked;
        int          led_writes;
        int          frame_ends;

        function new();
            scale_on  = 1'b1;
            angle     = 6'd45;
            code_one  = 8'd60;
            code_zero = 8'd30;
            foreach (grb_store[i])
                grb_store[i] = '0;
            slot_pos      = 0;
            mismatches    = 0;
            stray_codes   = 0;
            codes_checked = 0;
            led_writes    = 0;
            frame_ends    = 0;
        endfunction

        function void write_reg(cfg_index_t idx, logic [7:0] value);
            case (idx)
                CFG_BRIGHT_EN:  scale_on  = value[0];
                CFG_BRIGHT_LVL: angle     = value[5:0];
                CFG_DUTY_ONE:   code_one  = value;
                CFG_DUTY_ZERO:  code_zero = value;
                default: ;
            endcase
        endfunction

        // floor(c * tan(angle)), angles past the top give a scale of one
        function logic [7:0] dim(logic [7:0] c);
            logic [5:0]  a;
            logic [24:0] prod;
            a    = (angle > TOP_ANGLE) ? 6'(TOP_ANGLE) : angle;
            prod = c * TAN_Q16_LUT[a];
            return prod[23:16];
        endfunction

        // code of the current slot, then step to the next one
        function out_item_t next_code();
            out_item_t   res;
            logic [23:0] grb;
            int          bit_no;
            res = '0;
            if (slot_pos < LED_SLOTS)
            begin
                grb = grb_store[slot_pos / BITS_PER_LED];
                if (scale_on)
                    grb = {dim(grb[23:16]), dim(grb[15:8]), dim(grb[7:0])};
                bit_no   = BITS_PER_LED - 1 - (slot_pos % BITS_PER_LED);
                res.duty = grb[bit_no] ? code_one : code_zero;
            end
            else if (slot_pos == FRAME_LEN - 1)
            begin
                res.frame_end = 1'b1;
                frame_ends++;
            end
            slot_pos = (slot_pos == FRAME_LEN - 1) ? 0 : slot_pos + 1;
            return res;
        endfunction

        // accepted input item
        function void take_item(in_item_t item);
            if (item.func == FUNC_WRITE)
            begin
                if (int'(item.led_index) < LED_COUNT)
                    grb_store[item.led_index] = {item.green, item.red, item.blue};
                led_writes++;
            end
            else
                pending_codes.push_back(next_code());
        endfunction

        // accepted result item against the oldest expected code
        function void match_code(out_item_t got);
            out_item_t want;
            if (pending_codes.size() == 0)
            begin
                stray_codes++;
                if (mismatches + stray_codes <= SHOWN_ERRS)
                    $display("unexpected result: duty %0d frame_end %0b",
                             got.duty, got.frame_end);
                return;
            end
            want = pending_codes.pop_front();
            codes_checked++;
            if (got.duty !== want.duty || got.frame_end !== want.frame_end)
            begin
                mismatches++;
                if (mismatches + stray_codes <= SHOWN_ERRS)
                    $display("mismatch on slot code %0d: duty exp %0d got %0d, frame_end exp %0b got %0b",
                             codes_checked, want.duty, got.duty, want.frame_end, got.frame_end);
            end
        endfunction

        function int pending();
            return pending_codes.size();
        endfunction
    endclass

endpackage

/* tb/sv/tb_ws2812_frame_pwm_encoder.sv */
// tb_ws2812_frame_pwm_encoder: self-checking bench, led writes and slot requests with random idling
// depends on wfpe_pkg, ws2812_tb_pkg and the ws2812_frame_pwm_encoder rtl
`timescale 1ns / 1ps

module tb_ws2812_frame_pwm_encoder;
    import wfpe_pkg::*;
    import ws2812_tb_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int MIN_ITEMS     = 950;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    in_item_t   in_data   = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    out_item_t  out_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_index = CFG_BRIGHT_EN;
    logic [7:0] cfg_data  = 8'd0;

    frame_slot_tracker tracker;
    bit                no_gaps     = 1'b0;
    int                cycle_count = 0;
    int                items_sent  = 0;

    ws2812_frame_pwm_encoder uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 12 ns clock
    initial
    begin
        forever #6 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d codes outstanding",
                     cycle_count, tracker.pending());
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic in_item_t make_item(logic func, logic [5:0] idx,
                                           logic [7:0] r, logic [7:0] g, logic [7:0] b);
        in_item_t item;
        item.func      = func;
        item.led_index = idx;
        item.red       = r;
        item.green     = g;
        item.blue      = b;
        return item;
    endfunction

    // colour byte leaning towards the extremes
    function automatic logic [7:0] colour_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic in_item_t random_item(int slot_share);
        logic func;
        func = ($urandom_range(0, 99) < slot_share) ? FUNC_SLOT : FUNC_WRITE;
        return make_item(func, 6'($urandom_range(0, 63)), colour_byte(), colour_byte(),
                         colour_byte());
    endfunction

    // present one item after a random gap, return at the accepting edge
    task automatic send_item(in_item_t item);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 4);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_data  <= item;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        tracker.take_item(item);
        items_sent++;
    endtask

    // hold the input off until every expected code has come back
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_cfg(cfg_index_t idx, logic [7:0] value);
        @(negedge clk);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        tracker.write_reg(idx, value);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // registers change only once the block has gone quiet
    task automatic configure(logic [7:0] en_raw, logic [7:0] lvl_raw,
                             logic [7:0] one, logic [7:0] zero);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_cfg(CFG_BRIGHT_EN, en_raw);
        write_cfg(CFG_BRIGHT_LVL, lvl_raw);
        write_cfg(CFG_DUTY_ONE, one);
        write_cfg(CFG_DUTY_ZERO, zero);
    endtask

    // result side with random stalls
    initial
    begin : result_sink
        int stall;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = no_gaps ? 0 : $urandom_range(0, 4);
            @(negedge clk);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            tracker.match_code(out_data);
        end
    end

    // stimulus
    initial
    begin : stimulus
        int         phase;
        int         phase_len;
        int         slot_share;
        logic [7:0] lvl_pick;
        tracker = new();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: register reset values, index and colour extremes, 22 slot requests
        send_item(make_item(FUNC_WRITE, 6'd0, 8'h00, 8'hFF, 8'h5A));
        send_item(make_item(FUNC_WRITE, 6'd63, 8'hFF, 8'hFF, 8'hFF));
        send_item(make_item(FUNC_WRITE, 6'd1, 8'hFF, 8'h00, 8'h81));
        repeat (22)
            send_item(make_item(FUNC_SLOT, 6'($urandom_range(0, 63)),
                                8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                8'($urandom_range(0, 255))));

        // random phases, each under its own register setting
        phase = 0;
        while (items_sent < MIN_ITEMS)
        begin
            case (phase)
                // zero scale, duty codes at opposite extremes
                0: configure(8'h01, 8'h00, 8'hFF, 8'h00);
                // level 63 saturates, spare data bits set
                1: configure(8'hFF, 8'hFF, 8'h00, 8'hFF);
                // raw colours
                2: configure(8'hFE, 8'd23, 8'd60, 8'd30);
                // exact top angle, both codes at maximum
                3: configure(8'h01, 8'd45, 8'hFF, 8'hFF);
                default:
                begin
                    lvl_pick = 8'($urandom_range(0, 255));
                    if ($urandom_range(0, 3) != 0)
                        lvl_pick[5:0] = 6'($urandom_range(0, TOP_ANGLE));
                    configure(8'($urandom_range(0, 255)), lvl_pick,
                              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                end
            endcase
            no_gaps    = ($urandom_range(0, 3) == 0);
            phase_len  = $urandom_range(130, 170);
            slot_share = $urandom_range(70, 90);
            for (int i = 0; i < phase_len && items_sent < MIN_ITEMS; i++)
            begin
                if (phase == 1 && i == 120)
                    drain_results();
                send_item(random_item(slot_share));
            end
            phase++;
        end

        // wind down
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("run covered %0d items over %0d register settings: %0d led writes, %0d codes",
                 items_sent, phase, tracker.led_writes, tracker.codes_checked);
        $display("%0d frame ends seen, %0d mismatches, %0d unexpected codes",
                 tracker.frame_ends, tracker.mismatches, tracker.stray_codes);
        if (tracker.mismatches == 0 && tracker.stray_codes == 0 && tracker.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* filelist.f */
design/wfpe_pkg.sv
design/wfpe_ctrl.sv
design/wfpe_datapath.sv
design/ws2812_frame_pwm_encoder.sv
tb/sv/ws2812_tb_pkg.sv
tb/sv/tb_ws2812_frame_pwm_encoder.sv
